// ----- src/bwsr_pkg.sv -----
// shared constants and codes for the block write session receiver
// no dependencies
package bwsr_pkg;

    localparam int SESSIONS_DEF = 4;
    localparam int BLOCKS_DEF = 64;
    localparam int ADDR_BYTES_DEF = 4;

    localparam logic [15:0] TIMEOUT_RST = 16'd1000;
    localparam logic [15:0] POLL_RST = 16'd10;

    // input kinds
    localparam logic [2:0] K_REQ = 3'd0;
    localparam logic [2:0] K_ABORT = 3'd1;
    localparam logic [2:0] K_STATUS = 3'd2;
    localparam logic [2:0] K_XFER = 3'd3;
    localparam logic [2:0] K_WDONE = 3'd5;
    localparam logic [2:0] K_TICK = 3'd6;
    localparam logic [2:0] K_NONE = 3'd7;

    // reply kinds
    localparam logic [1:0] R_ACK = 2'd0;
    localparam logic [1:0] R_NACK = 2'd1;
    localparam logic [1:0] R_STAT = 2'd2;
    localparam logic [1:0] R_WORD = 2'd3;

    // session states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RECV = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_NODE = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_POLL = 2'd2;

    // keep the low n bytes of a word
    function automatic logic [63:0] low_bytes(input logic [63:0] v, input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) m[i*8 +: 8] = 8'hff;
        end
        return v & m;
    endfunction

endpackage

// ----- src/bwsr_buf.sv -----
// block buffer memory, one write port and one registered read port
// no dependencies
module bwsr_buf #(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [63:0]              i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [63:0]              o_rdata
);
    logic [63:0] r_mem [DEPTH];

    // synchronous write and read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/block_write_session_receiver.sv -----
// top level of the block write session receiver
// depends on bwsr_pkg and bwsr_buf
// A frame (start while not busy) is latched and then handled in ST_FRAME, giving
// at most one reply there; a tick walks the sessions, one per cycle. A transfer
// that completes a set streams all blocks from the buffer memory, one word a
// cycle, each word read through the registered read port of the buffer; the
// block takes new frames again only after the last word is out.
// Results show for one cycle with o_valid; the receiver cannot stall them.
module block_write_session_receiver #(
    parameter int SESSIONS = bwsr_pkg::SESSIONS_DEF,
    parameter int BLOCKS_PER_SESSION = bwsr_pkg::BLOCKS_DEF,
    parameter int ADDRESS_BYTES = bwsr_pkg::ADDR_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_source_node,
    input  logic [5:0]  i_seq,
    input  logic [3:0]  i_length,
    input  logic [63:0] i_data,
    input  logic        i_write_allowed,
    input  logic [1:0]  i_slot,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_reply_kind,
    output logic [7:0]  o_dest_node,
    output logic [7:0]  o_src_node,
    output logic [5:0]  o_seq_res,
    output logic [3:0]  o_length_res,
    output logic [63:0] o_data_res,
    output logic        o_written,
    output logic [31:0] o_write_address,
    output logic [9:0]  o_write_size,
    output logic        o_last
);
    import bwsr_pkg::*;

    localparam int SW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int BW = $clog2(BLOCKS_PER_SESSION);
    localparam int AW = $clog2(SESSIONS * BLOCKS_PER_SESSION);

    typedef enum logic [2:0] {ST_IDLE, ST_FRAME, ST_TICK, ST_STREAM} t_state;

    t_state r_state;
    logic [7:0]  r_node;
    logic [15:0] r_timeout, r_poll;

    // per-session control, small enough for flip-flops
    logic [1:0]  r_sst [SESSIONS];
    logic [7:0]  r_ssrc [SESSIONS];
    logic [31:0] r_addr [SESSIONS];
    logic [5:0]  r_lidx [SESSIONS];
    logic [3:0]  r_lbytes [SESSIONS];
    logic        r_wdone [SESSIONS];
    logic [15:0] r_ticks [SESSIONS];
    logic [63:0] r_map [SESSIONS];

    // latched input word
    logic [2:0]  r_kind;
    logic [7:0]  r_src;
    logic [5:0]  r_seq;
    logic [3:0]  r_len;
    logic [63:0] r_data;
    logic        r_allow;
    logic [SW-1:0] r_cur;
    logic [5:0]  r_blk;
    logic        r_rdv;

    // buffer port
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [63:0]   w_rdata;

    bwsr_buf #(.DEPTH(SESSIONS * BLOCKS_PER_SESSION)) u_buf (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(low_bytes(r_data, r_len)),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign busy = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // session lookup and free slot search
    logic          w_found, w_free;
    logic [SW-1:0] w_fidx, w_freeidx;
    always_comb begin
        w_found = 1'b0;
        w_free = 1'b0;
        w_fidx = '0;
        w_freeidx = '0;
        for (int s = SESSIONS - 1; s >= 0; s--) begin
            if (r_sst[s] != S_IDLE && r_ssrc[s] == r_src) begin
                w_found = 1'b1;
                w_fidx = SW'(s);
            end
            if (r_sst[s] == S_IDLE) begin
                w_free = 1'b1;
                w_freeidx = SW'(s);
            end
        end
    end

    // transfer checks on the matched session
    logic [5:0]  w_mx;
    logic        w_xok, w_full;
    logic [63:0] w_nmap, w_need;
    always_comb begin
        w_mx = r_lidx[w_fidx];
        w_xok = r_sst[w_fidx] == S_RECV && (BW == 6 || r_seq < 6'(BLOCKS_PER_SESSION))
              && ((r_seq < w_mx && r_len == 4'd8)
                  || (r_seq == w_mx && r_len != 4'd0 && r_len <= 4'd8));
        w_nmap = r_map[w_fidx] | (64'd1 << r_seq);
        w_need = (w_mx == 6'd63) ? '1 : ((64'd1 << (w_mx + 6'd1)) - 64'd1);
        w_full = (w_nmap & w_need) == w_need;
    end

    logic [3:0] w_nb;
    assign w_nb = 4'((7'(r_lidx[w_fidx]) + 7'd8) >> 3);

    assign w_we = r_state == ST_FRAME && r_kind == K_XFER && w_found && w_xok;
    assign w_waddr = AW'({w_fidx, r_seq[BW-1:0]});
    assign w_raddr = AW'({r_cur, r_blk[BW-1:0]});

    // control, session state and outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_node <= '0;
            r_timeout <= TIMEOUT_RST;
            r_poll <= POLL_RST;
            o_valid <= 1'b0;
            r_rdv <= 1'b0;
            for (int s = 0; s < SESSIONS; s++) begin
                r_sst[s] <= S_IDLE;
                r_ssrc[s] <= '0;
                r_lidx[s] <= '0;
                r_lbytes[s] <= '0;
                r_wdone[s] <= 1'b0;
                r_ticks[s] <= '0;
                r_map[s] <= '0;
            end
        end else begin
            o_valid <= 1'b0;
            // configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_NODE:    r_node <= i_cfg_data[7:0];
                    CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    CFG_POLL:    r_poll <= i_cfg_data;
                    default:     ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_kind <= i_kind;
                        r_src <= i_source_node;
                        r_seq <= i_seq;
                        r_len <= i_length;
                        r_data <= i_data;
                        r_allow <= i_write_allowed;
                        r_cur <= '0;
                        if (i_kind == K_WDONE) begin
                            if (32'(i_slot) < SESSIONS) r_wdone[SW'(i_slot)] <= 1'b1;
                        end else if (i_kind == K_TICK) begin
                            r_state <= ST_TICK;
                        end else if (i_kind != K_NONE) begin
                            r_state <= ST_FRAME;
                        end
                    end
                end
                ST_TICK: begin
                    // one session per cycle
                    if (r_sst[r_cur] != S_IDLE) begin
                        if (r_ticks[r_cur] <= 16'd1) begin
                            if (r_sst[r_cur] == S_WRITE) begin
                                if (r_wdone[r_cur]) begin
                                    r_sst[r_cur] <= S_DONE;
                                    r_ticks[r_cur] <= r_timeout;
                                end else begin
                                    r_ticks[r_cur] <= r_poll;
                                end
                            end else begin
                                r_sst[r_cur] <= S_IDLE;
                                r_ticks[r_cur] <= '0;
                            end
                        end else begin
                            r_ticks[r_cur] <= r_ticks[r_cur] - 16'd1;
                        end
                    end
                    if (32'(r_cur) == SESSIONS - 1) r_state <= ST_IDLE;
                    else r_cur <= r_cur + SW'(1);
                end
                ST_FRAME: begin
                    // default reply is a nack
                    r_state <= ST_IDLE;
                    o_valid <= 1'b1;
                    o_reply_kind <= R_NACK;
                    o_dest_node <= r_src;
                    o_src_node <= r_node;
                    o_seq_res <= '0;
                    o_length_res <= '0;
                    o_data_res <= '0;
                    o_written <= 1'b0;
                    o_write_address <= '0;
                    o_write_size <= '0;
                    o_last <= 1'b1;
                    if (w_found != (r_kind == K_REQ)) begin
                        case (r_kind)
                            K_REQ: begin
                                if (w_free && r_len != 4'd0 && r_len <= 4'(ADDRESS_BYTES)
                                    && r_allow && 32'(r_seq) < BLOCKS_PER_SESSION) begin
                                    r_addr[w_freeidx] <= 32'(low_bytes(r_data, r_len));
                                    r_ssrc[w_freeidx] <= r_src;
                                    r_lidx[w_freeidx] <= r_seq;
                                    r_map[w_freeidx] <= '0;
                                    r_sst[w_freeidx] <= S_RECV;
                                    r_ticks[w_freeidx] <= r_timeout;
                                    o_reply_kind <= R_ACK;
                                    o_seq_res <= r_seq;
                                    o_length_res <= r_len;
                                    o_data_res <= low_bytes(r_data, r_len);
                                end
                            end
                            K_ABORT: begin
                                if (r_len == 4'd0) begin
                                    r_sst[w_fidx] <= S_IDLE;
                                    r_ticks[w_fidx] <= r_timeout;
                                    o_reply_kind <= R_ACK;
                                    o_seq_res <= r_seq;
                                end
                            end
                            K_STATUS: begin
                                if (r_len == 4'd0) begin
                                    r_ticks[w_fidx] <= (r_sst[w_fidx] == S_WRITE)
                                                       ? r_poll : r_timeout;
                                    o_reply_kind <= R_STAT;
                                    o_length_res <= w_nb;
                                    o_data_res <= low_bytes(r_map[w_fidx], w_nb);
                                    o_written <= (r_sst[w_fidx] == S_WRITE && r_wdone[w_fidx])
                                                 || r_sst[w_fidx] == S_DONE;
                                end
                            end
                            K_XFER: begin
                                if (w_xok) begin
                                    o_valid <= 1'b0;
                                    r_map[w_fidx] <= w_nmap;
                                    if (r_seq == w_mx) r_lbytes[w_fidx] <= r_len;
                                    if (w_full) begin
                                        r_wdone[w_fidx] <= 1'b0;
                                        r_sst[w_fidx] <= S_WRITE;
                                        r_ticks[w_fidx] <= r_poll;
                                        r_cur <= w_fidx;
                                        r_blk <= '0;
                                        r_rdv <= 1'b0;
                                        r_state <= ST_STREAM;
                                    end else begin
                                        r_ticks[w_fidx] <= r_timeout;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_STREAM: begin
                    // read address leads the emitted word through the registered read port
                    if (r_blk != r_lidx[r_cur]) r_blk <= r_blk + 6'd1;
                    r_rdv <= 1'b1;
                    if (r_rdv) begin
                        o_valid <= 1'b1;
                        o_reply_kind <= R_WORD;
                        o_dest_node <= '0;
                        o_src_node <= '0;
                        o_seq_res <= r_seq;
                        o_data_res <= w_rdata;
                        o_written <= 1'b0;
                        o_write_address <= r_addr[r_cur];
                        o_write_size <= 10'({r_lidx[r_cur], 3'b000}) + 10'(r_lbytes[r_cur]);
                        o_length_res <= (r_seq == r_lidx[r_cur]) ? r_lbytes[r_cur] : 4'd8;
                        o_last <= (r_seq == r_lidx[r_cur]);
                        if (r_seq == r_lidx[r_cur]) r_state <= ST_IDLE;
                        else r_seq <= r_seq + 6'd1;
                    end else begin
                        r_seq <= '0;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- tb/tb_block_write_session_receiver.sv -----
// self-checking testbench for block_write_session_receiver: directed then random frames,
// with the expected replies and write words worked out by a behavioral session model
// depends on bwsr_pkg and the block write session receiver rtl
module tb_block_write_session_receiver;
    import bwsr_pkg::*;

    localparam int NSESS = 4;
    localparam int NBLK = 64;
    localparam int LIMIT = 400000;
    localparam int SETTLE = 100;
    localparam logic [2:0] K_OTHER = 3'd4;

    typedef enum logic [1:0] {IT_FRAME, IT_CFG, IT_PAUSE} t_item_tag;

    typedef struct {
        t_item_tag   tag;
        logic [2:0]  kind;
        logic [7:0]  src;
        logic [5:0]  seq;
        logic [3:0]  len;
        logic [63:0] data;
        logic        allowed;
        logic [1:0]  slot;
        logic [1:0]  cfg_idx;
        logic [15:0] cfg_val;
    } t_frame;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  dest;
        logic [7:0]  src;
        logic [5:0]  seq;
        logic [3:0]  len;
        logic [63:0] data;
        logic        wr;
        logic [31:0] addr;
        logic [9:0]  size;
        logic        last;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_kind;
    logic [7:0]  i_source_node;
    logic [5:0]  i_seq;
    logic [3:0]  i_length;
    logic [63:0] i_data;
    logic        i_write_allowed;
    logic [1:0]  i_slot;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    logic [1:0]  o_reply_kind;
    logic [7:0]  o_dest_node;
    logic [7:0]  o_src_node;
    logic [5:0]  o_seq_res;
    logic [3:0]  o_length_res;
    logic [63:0] o_data_res;
    logic        o_written;
    logic [31:0] o_write_address;
    logic [9:0]  o_write_size;
    logic        o_last;

    block_write_session_receiver uut (.*);

    // session model state
    logic [63:0] blk_mem [NSESS*NBLK];
    logic [63:0] rx_map [NSESS];
    logic [1:0]  sess_st [NSESS];
    logic [7:0]  sess_src [NSESS];
    logic [31:0] sess_addr [NSESS];
    logic [5:0]  sess_last_idx [NSESS];
    logic [3:0]  sess_last_len [NSESS];
    logic        sess_done [NSESS];
    logic [15:0] sess_ticks [NSESS];
    logic [7:0]  my_node;
    logic [15:0] timeout_ticks;
    logic [15:0] poll_ticks;

    t_frame pending_q[$];
    t_reply expected_q[$];
    int     errors;
    int     frames_taken;
    int     words_seen;
    int     cfg_writes;
    int     cycles;
    int     quiet;
    int     gap;
    bit     no_idle;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] keep_bytes(logic [63:0] v, int n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) if (i < n) r[i*8 +: 8] = v[i*8 +: 8];
        return r;
    endfunction

    function automatic void reload_timer(int s);
        sess_ticks[s] = (sess_st[s] == S_WRITE) ? poll_ticks : timeout_ticks;
    endfunction

    function automatic void push_reply(logic [1:0] k, logic [7:0] d, logic [7:0] sr,
                                       logic [5:0] sq, logic [3:0] l, logic [63:0] dt,
                                       logic w, logic [31:0] a, logic [9:0] sz, logic lst);
        t_reply r;
        r = '{k, d, sr, sq, l, dt, w, a, sz, lst};
        expected_q.push_back(r);
    endfunction

    function automatic void push_nack(logic [7:0] s);
        push_reply(R_NACK, s, my_node, 0, 0, 0, 0, 0, 0, 1'b1);
    endfunction

    // expected replies for one accepted frame, updating the session model
    function automatic void predict_replies(t_frame f);
        int hit;
        int fr;
        int mx;
        int nb;
        bit all_in;
        logic [9:0] total;
        hit = -1;
        fr = -1;
        if (f.kind == K_TICK) begin
            for (int s = 0; s < NSESS; s++) begin
                if (sess_st[s] == S_IDLE) continue;
                if (sess_ticks[s] <= 16'd1) begin
                    sess_ticks[s] = '0;
                    if (sess_st[s] == S_WRITE) begin
                        if (sess_done[s]) sess_st[s] = S_DONE;
                        reload_timer(s);
                    end else begin
                        sess_st[s] = S_IDLE;
                    end
                end else begin
                    sess_ticks[s] = sess_ticks[s] - 16'd1;
                end
            end
            return;
        end
        if (f.kind == K_WDONE) begin
            sess_done[f.slot] = 1'b1;
            return;
        end
        if (f.kind == K_NONE) return;
        for (int s = 0; s < NSESS; s++) begin
            if (hit < 0 && sess_st[s] != S_IDLE && sess_src[s] == f.src) hit = s;
        end
        if ((hit >= 0) == (f.kind == K_REQ)) begin
            push_nack(f.src);
            return;
        end
        case (f.kind)
            K_REQ: begin
                for (int s = 0; s < NSESS; s++) if (fr < 0 && sess_st[s] == S_IDLE) fr = s;
                if (fr >= 0 && f.len != 0 && f.len <= 4 && f.allowed) begin
                    sess_addr[fr] = 32'(keep_bytes(f.data, f.len));
                    sess_src[fr] = f.src;
                    sess_last_idx[fr] = f.seq;
                    rx_map[fr] = '0;
                    sess_st[fr] = S_RECV;
                    reload_timer(fr);
                    push_reply(R_ACK, f.src, my_node, f.seq, f.len, keep_bytes(f.data, f.len),
                               0, 0, 0, 1'b1);
                    return;
                end
            end
            K_ABORT: begin
                if (f.len == 0) begin
                    sess_st[hit] = S_IDLE;
                    reload_timer(hit);
                    push_reply(R_ACK, f.src, my_node, f.seq, 0, 0, 0, 0, 0, 1'b1);
                    return;
                end
            end
            K_STATUS: begin
                if (f.len == 0) begin
                    nb = (sess_last_idx[hit] + 8) / 8;
                    reload_timer(hit);
                    push_reply(R_STAT, f.src, my_node, 0, 4'(nb), keep_bytes(rx_map[hit], nb),
                               (sess_st[hit] == S_WRITE && sess_done[hit])
                               || sess_st[hit] == S_DONE, 0, 0, 1'b1);
                    return;
                end
            end
            K_XFER: begin
                mx = sess_last_idx[hit];
                if (sess_st[hit] == S_RECV && ((f.seq < mx && f.len == 8)
                        || (f.seq == mx && f.len > 0 && f.len <= 8))) begin
                    if (f.seq == mx) sess_last_len[hit] = f.len;
                    rx_map[hit][f.seq] = 1'b1;
                    blk_mem[hit*NBLK + f.seq] = keep_bytes(f.data, f.len);
                    all_in = 1;
                    for (int b = 0; b <= mx; b++) if (!rx_map[hit][b]) all_in = 0;
                    if (all_in) begin
                        total = 10'(mx * 8 + sess_last_len[hit]);
                        sess_done[hit] = 1'b0;
                        sess_st[hit] = S_WRITE;
                        reload_timer(hit);
                        for (int b = 0; b <= mx; b++) begin
                            push_reply(R_WORD, 0, 0, 6'(b),
                                       (b == mx) ? sess_last_len[hit] : 4'd8,
                                       blk_mem[hit*NBLK + b], 0, sess_addr[hit], total,
                                       b == mx);
                        end
                    end else begin
                        reload_timer(hit);
                    end
                    return;
                end
            end
            default: ;
        endcase
        push_nack(f.src);
    endfunction

    // stimulus builders
    task automatic add_frame(logic [2:0] k, logic [7:0] s, logic [5:0] sq, logic [3:0] l,
                             logic [63:0] d, logic a, logic [1:0] sl);
        t_frame f;
        f = '{IT_FRAME, k, s, sq, l, d, a, sl, 0, 0};
        pending_q.push_back(f);
    endtask

    task automatic add_cfg(logic [1:0] idx, logic [15:0] v);
        t_frame f;
        f = '{IT_CFG, 0, 0, 0, 0, 0, 0, 0, idx, v};
        pending_q.push_back(f);
    endtask

    task automatic add_pause();
        t_frame f;
        f = '{IT_PAUSE, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        pending_q.push_back(f);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // one mostly well-formed session from a sender, with some noise mixed in
    task automatic add_session(ref int n);
        logic [7:0] s;
        int mx;
        int order[$];
        int j;
        int tmp;
        s = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 5));
        mx = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 63) : $urandom_range(0, 6);
        add_frame(K_REQ, s, 6'(mx), ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 8))
                  : 4'($urandom_range(1, 4)), rand64(), $urandom_range(0, 9) != 0, 2'd0);
        n++;
        for (int b = 0; b <= mx; b++) order.push_back(b);
        for (int b = mx; b > 0; b--) begin
            j = $urandom_range(0, b);
            tmp = order[b];
            order[b] = order[j];
            order[j] = tmp;
        end
        foreach (order[i]) begin
            case ($urandom_range(0, 11))
                0: add_frame(K_STATUS, s, 6'($urandom()), ($urandom_range(0, 3) == 0)
                             ? 4'($urandom_range(1, 8)) : 4'd0, rand64(), 1'($urandom()),
                             2'd0);
                1: add_frame(K_XFER, s, 6'($urandom()), 4'($urandom_range(0, 15)), rand64(),
                             1'($urandom()), 2'd0);
                2: add_frame(K_TICK, 0, 0, 0, 0, 0, 0);
                3: add_frame(K_OTHER, 8'($urandom()), 6'($urandom()), 4'($urandom()),
                             rand64(), 1'($urandom()), 2'($urandom()));
                default: ;
            endcase
            n++;
            add_frame(K_XFER, s, 6'(order[i]), (order[i] == mx) ? 4'($urandom_range(1, 8))
                      : 4'd8, rand64(), 1'($urandom()), 2'($urandom()));
            n++;
        end
        // completion, polling and wrap-up
        if ($urandom_range(0, 1)) begin
            add_frame(K_WDONE, 0, 0, 0, 0, 0, 2'($urandom()));
            n++;
        end
        for (int t = $urandom_range(0, 6); t > 0; t--) begin
            add_frame(K_TICK, 0, 0, 0, 0, 0, 0);
            n++;
        end
        add_frame(K_STATUS, s, 0, 0, 0, 0, 0);
        n++;
        if ($urandom_range(0, 2) != 0) begin
            add_frame(K_ABORT, s, 6'($urandom()), ($urandom_range(0, 4) == 0) ? 4'd2 : 4'd0,
                      0, 0, 0);
            n++;
        end
    endtask

    // directed cases followed by random phases over several register settings
    initial begin
        int n;
        i_rst_n = 1'b0;
        add_cfg(CFG_NODE, 16'h00a5);
        add_cfg(CFG_TIMEOUT, 16'd3);
        add_cfg(CFG_POLL, 16'd2);
        add_frame(K_REQ, 8'h00, 0, 0, rand64(), 1, 0);
        add_frame(K_REQ, 8'h00, 0, 5, rand64(), 1, 0);
        add_frame(K_REQ, 8'h00, 0, 2, rand64(), 0, 0);
        add_frame(K_OTHER, 8'hff, 6'h3f, 4'd8, '1, 1, 2'd3);
        add_frame(K_STATUS, 8'h11, 0, 0, 0, 0, 0);
        add_frame(K_NONE, 8'h11, 0, 0, 0, 0, 0);
        add_frame(K_WDONE, 0, 0, 0, 0, 0, 2'd3);
        add_frame(K_REQ, 8'hff, 1, 4, '1, 1, 0);
        add_frame(K_REQ, 8'hff, 1, 4, '1, 1, 0);
        add_frame(K_STATUS, 8'hff, 0, 0, 0, 0, 0);
        add_frame(K_ABORT, 8'hff, 0, 1, 0, 0, 0);
        add_frame(K_XFER, 8'hff, 2, 8, rand64(), 0, 0);
        add_frame(K_XFER, 8'hff, 0, 7, rand64(), 0, 0);
        add_frame(K_XFER, 8'hff, 1, 0, rand64(), 0, 0);
        add_frame(K_XFER, 8'hff, 0, 8, '1, 0, 0);
        add_frame(K_XFER, 8'hff, 1, 3, rand64(), 0, 0);
        add_frame(K_WDONE, 0, 0, 0, 0, 0, 2'd0);
        for (int t = 0; t < 3; t++) add_frame(K_TICK, 0, 0, 0, 0, 0, 0);
        add_frame(K_STATUS, 8'hff, 0, 0, 0, 0, 0);
        for (int t = 0; t < 4; t++) add_frame(K_TICK, 0, 0, 0, 0, 0, 0);
        add_frame(K_STATUS, 8'hff, 0, 0, 0, 0, 0);
        add_frame(K_REQ, 8'h80, 6'h3f, 1, rand64(), 1, 0);
        add_frame(K_ABORT, 8'h80, 6'h2a, 0, 0, 0, 0);
        add_pause();

        n = 0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    add_cfg(CFG_NODE, 16'(8'($urandom())));
                    add_cfg(CFG_TIMEOUT, 16'($urandom_range(2, 40)));
                    add_cfg(CFG_POLL, 16'($urandom_range(1, 6)));
                end
                1: begin
                    add_cfg(CFG_NODE, 16'hff);
                    add_cfg(CFG_TIMEOUT, 16'hffff);
                    add_cfg(CFG_POLL, 16'hffff);
                end
                2: begin
                    add_cfg(CFG_NODE, 16'h00);
                    add_cfg(CFG_TIMEOUT, 16'd1);
                    add_cfg(CFG_POLL, 16'd1);
                end
                default: begin
                    add_cfg(CFG_NODE, 16'(8'($urandom())));
                    add_cfg(CFG_TIMEOUT, 16'($urandom_range(5, 60)));
                    add_cfg(CFG_POLL, 16'($urandom_range(1, 4)));
                end
            endcase
            while (n < (ph + 1) * 62) begin
                if ($urandom_range(0, 9) == 0) begin
                    add_frame(3'($urandom_range(0, 7)), 8'($urandom()), 6'($urandom()),
                              4'($urandom()), rand64(), 1'($urandom()), 2'($urandom()));
                    n++;
                end else begin
                    add_session(n);
                end
            end
            add_pause();
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_q.size() == 0 && !start && !i_cfg_valid);
        wait (expected_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d frames, %0d result words, %0d register writes",
                 frames_taken, words_seen, cfg_writes);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("PASS block_write_session_receiver");
        end else begin
            $display("FAIL block_write_session_receiver");
        end
        $finish;
    end

    // driver: frames, register writes and pauses from the pending queue
    initial begin
        start = 1'b0;
        i_kind = '0;
        i_source_node = '0;
        i_seq = '0;
        i_length = '0;
        i_data = '0;
        i_write_allowed = 1'b0;
        i_slot = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        frames_taken = 0;
        words_seen = 0;
        cfg_writes = 0;
        cycles = 0;
        quiet = 0;
        gap = 0;
        no_idle = 1'b0;
    end

    always @(posedge i_clk) begin
        t_frame cur;
        bit     next_start;
        bit     in_flight;
        in_flight = start;
        quiet = (o_valid || start) ? 0 : quiet + 1;
        if (start && !busy) begin
            predict_replies(pending_q.pop_front());
            frames_taken++;
            in_flight = 0;
            quiet = 0;
            if (no_idle) gap = 0;
            else if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 40);
            else gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
        end
        if (i_cfg_valid && o_cfg_ready) begin
            cur = pending_q.pop_front();
            case (cur.cfg_idx)
                CFG_NODE: my_node = cur.cfg_val[7:0];
                CFG_TIMEOUT: timeout_ticks = cur.cfg_val;
                CFG_POLL: poll_ticks = cur.cfg_val;
                default: ;
            endcase
            cfg_writes++;
            i_cfg_valid <= 1'b0;
        end else if (!i_cfg_valid && !in_flight && i_rst_n && pending_q.size() != 0) begin
            cur = pending_q[0];
            if (cur.tag == IT_CFG && expected_q.size() == 0 && quiet >= SETTLE) begin
                i_cfg_valid <= 1'b1;
                i_cfg_index <= cur.cfg_idx;
                i_cfg_data <= cur.cfg_val;
            end else if (cur.tag == IT_PAUSE && expected_q.size() == 0) begin
                void'(pending_q.pop_front());
                no_idle = ~no_idle;
            end
        end
        // keep start high across back-to-back frames
        next_start = 1'b0;
        if (!in_flight && gap > 0) begin
            gap--;
        end else if (in_flight) begin
            next_start = 1'b1;
        end else if (i_rst_n && !i_cfg_valid && pending_q.size() != 0
                     && pending_q[0].tag == IT_FRAME) begin
            cur = pending_q[0];
            next_start = 1'b1;
            i_kind <= cur.kind;
            i_source_node <= cur.src;
            i_seq <= cur.seq;
            i_length <= cur.len;
            i_data <= cur.data;
            i_write_allowed <= cur.allowed;
            i_slot <= cur.slot;
        end
        start <= next_start;
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // monitor: compare every result word against the oldest expectation
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_valid) begin
            words_seen++;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result: expected none actual kind %0d dest %h",
                         $time, o_reply_kind, o_dest_node);
                errors++;
            end else begin
                want = expected_q.pop_front();
                check_field("reply_kind", 64'(want.kind), 64'(o_reply_kind));
                check_field("dest_node", 64'(want.dest), 64'(o_dest_node));
                check_field("src_node", 64'(want.src), 64'(o_src_node));
                check_field("seq_res", 64'(want.seq), 64'(o_seq_res));
                check_field("length_res", 64'(want.len), 64'(o_length_res));
                check_field("data_res", want.data, o_data_res);
                check_field("written", 64'(want.wr), 64'(o_written));
                check_field("write_address", 64'(want.addr), 64'(o_write_address));
                check_field("write_size", 64'(want.size), 64'(o_write_size));
                check_field("last", 64'(want.last), 64'(o_last));
            end
        end
    end

    // model reset and run limit
    initial begin
        for (int s = 0; s < NSESS; s++) begin
            rx_map[s] = '0;
            sess_st[s] = S_IDLE;
            sess_src[s] = '0;
            sess_addr[s] = '0;
            sess_last_idx[s] = '0;
            sess_last_len[s] = '0;
            sess_done[s] = 1'b0;
            sess_ticks[s] = '0;
        end
        my_node = '0;
        timeout_ticks = TIMEOUT_RST;
        poll_ticks = POLL_RST;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_q.size());
            $display("FAIL block_write_session_receiver");
            $finish;
        end
    end

endmodule
